/* sv/dees_pkg.sv */
// shared types and constants of the deadline expiry edf server
`default_nettype none

package dees_pkg;

    // number of deadline buckets in the ring (one cell each)
    localparam int WINDOW      = 64;

    localparam int UNITS_W     = 16;
    localparam int LIFE_W      = 6;
    localparam int CNT_W       = 24;
    localparam int TOTAL_W     = 32;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((UNITS_W + LIFE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((1 + TOTAL_W + 1 + 7) / 8) * 8;

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // per-cell control group
    typedef struct packed {
        logic add;   // add arriving units to this bucket
        logic clr;   // expire this bucket
        logic dec;   // serve one unit from this bucket
        logic step;  // take the neighbor's value (advance one tick)
    } t_cell_ctl;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SERVE
    } t_state;

endpackage

`default_nettype wire

/* sv/deadline_expiry_edf_server_core.sv */
// top level of the deadline expiry edf server: bucket chain, serve select, stream ports
//
//  channel  | dir | tdata fields (lowest bit up)                       | tuser/tlast
//  ---------+-----+----------------------------------------------------+------------
//  s_axis   | in  | arrival_units[15:0], lifetime[21:16], zero pad     | none
//  m_axis   | out | served[0], total_served[32:1], pending[33], pad    | none
//
// a tick runs through the idle and serve states: the accepted input adds the arrivals to
// their bucket and expires the current bucket, then the serve state serves from the
// earliest nonempty bucket and shifts the whole chain down by one cell; no new tick is
// accepted until serve completes, and the path runs through the 64-wide select.
// reset (synchronous, active low) clears all buckets, the running total and the
// output valid flag. a stalled result holds the block in its serve cycle.
`default_nettype none

module deadline_expiry_edf_server_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // arrival_units[15:0], lifetime[21:16], zero pad above
    input  wire logic [dees_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // served[0], total_served[32:1], pending[33], zero pad above
    output logic      [dees_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import dees_pkg::*;

    t_state r_state;
    t_state n_state;

    // cell k holds the bucket whose deadline is the current tick plus k
    t_cell_ctl                ctl   [WINDOW];
    logic [CNT_W-1:0]         post  [WINDOW];
    logic [WINDOW-1:0]        nz;
    logic [WINDOW-1:0]        keep;
    logic [WINDOW-1:0]        flags;
    logic [WINDOW-1:0]        grant;
    logic                     any_srv;

    logic [UNITS_W-1:0]       units;
    logic [LIFE_W-1:0]        life;
    logic                     accept;
    logic                     commit;
    logic                     pend;

    logic [TOTAL_W-1:0]       r_total;
    logic [TOTAL_W-1:0]       n_total;

    logic                     r_out_valid;
    logic                     r_out_served;
    logic [TOTAL_W-1:0]       r_out_total;
    logic                     r_out_pending;

    assign units = s_axis_tdata[UNITS_W-1:0];
    assign life  = s_axis_tdata[UNITS_W +: LIFE_W];

    // input transaction completes
    assign accept = s_axis_tvalid && s_axis_tready;
    // serve cycle may finish once the output register is free
    assign commit = (r_state == ST_SERVE) && (!r_out_valid || m_axis_tready);

    // state register and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_SERVE;
                end
            end
            ST_SERVE: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // bucket chain
    for (genvar j = 0; j < WINDOW; j++) begin : g_cell
        logic             life_hit;
        logic [CNT_W-1:0] next_val;

        // lifetimes beyond the ring saturate to the last cell
        assign life_hit = (j != 0) &&
                          ((int'(life) == j) || ((j == WINDOW - 1) && (int'(life) > j)));

        assign ctl[j].add  = accept && (units != '0) && life_hit;
        assign ctl[j].clr  = accept && (j == 0);
        assign ctl[j].dec  = commit && grant[j];
        assign ctl[j].step = commit;

        if (j == WINDOW - 1) begin : g_tail
            // the expired bucket reenters as the farthest deadline, empty
            assign next_val = '0;
        end else begin : g_body
            assign next_val = post[j+1];
        end

        dees_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[j]),
            .i_units (units),
            .i_next  (next_val),
            .o_post  (post[j]),
            .o_nz    (nz[j]),
            .o_keep  (keep[j])
        );
    end

    // cell zero is the current deadline and is never served
    assign flags = {nz[WINDOW-1:1], 1'b0};

    dees_pick u_pick (
        .i_flags (flags),
        .o_grant (grant),
        .o_any   (any_srv)
    );

    // anything left after the serve
    assign pend = |keep;

    // saturating running total
    always_comb begin
        n_total = r_total;
        if (commit && any_srv && (r_total != TOTAL_MAX)) begin
            n_total = r_total + {{(TOTAL_W - 1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_served  <= any_srv;
            r_out_total   <= n_total;
            r_out_pending <= pend;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - TOTAL_W - 2){1'b0}},
                            r_out_pending, r_out_total, r_out_served};

`ifndef SYNTHESIS
    a_grant_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(grant))
        else $error("serve grant not one-hot");

    a_total_monotonic: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_total >= $past(r_total)))
        else $error("running total went down");

    a_served_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_served) |-> (r_out_total != '0))
        else $error("served result with zero total");

    a_empty_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && !pend) |=> (nz == '0))
        else $error("buckets nonempty after a tick reported no pending units");

    a_expired_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (post[0] == '0))
        else $error("current deadline bucket not empty in its serve cycle");
`endif

endmodule

`default_nettype wire

/* sv/dees_cell.sv */
// one deadline bucket of the shifting bucket chain
`default_nettype none

module dees_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dees_pkg::t_cell_ctl           i_ctl,
    input  wire logic [dees_pkg::UNITS_W-1:0]  i_units,
    input  wire logic [dees_pkg::CNT_W-1:0]    i_next,
    output logic      [dees_pkg::CNT_W-1:0]    o_post,
    output logic                               o_nz,
    output logic                               o_keep
);
    import dees_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] sat;

    always_comb begin
        sum    = {1'b0, r_cnt} + {{(CNT_W + 1 - UNITS_W){1'b0}}, i_units};
        sat    = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
        // value after a possible serve
        o_post = r_cnt - {{(CNT_W - 1){1'b0}}, i_ctl.dec};
        o_nz   = |r_cnt;
        o_keep = |o_post;
        if (i_ctl.step) begin
            n_cnt = i_next;
        end else if (i_ctl.clr) begin
            n_cnt = '0;
        end else if (i_ctl.add) begin
            n_cnt = sat;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* sv/dees_pick.sv */
// earliest nonempty bucket select: lowest set flag as a one-hot grant
`default_nettype none

module dees_pick (
    input  wire logic [dees_pkg::WINDOW-1:0] i_flags,
    output logic      [dees_pkg::WINDOW-1:0] o_grant,
    output logic                             o_any
);
    import dees_pkg::*;

    always_comb begin
        // isolate lowest set bit with one wide add
        o_grant = i_flags & (~i_flags + {{(WINDOW - 1){1'b0}}, 1'b1});
        o_any   = |i_flags;
    end

endmodule

`default_nettype wire

/* tb/sv/edf_service_checker.sv */
// checker for the deadline expiry edf server: predicts each tick result and compares it
`timescale 1ns / 100ps

module edf_service_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_tvalid,
    input  wire logic                             i_in_tready,
    // arrival_units[15:0], lifetime[21:16], zero pad above
    input  wire logic [dees_pkg::IN_TDATA_W-1:0]  i_in_tdata,
    input  wire logic                             i_out_tvalid,
    input  wire logic                             i_out_tready,
    // served[0], total_served[32:1], pending[33], zero pad above
    input  wire logic [dees_pkg::OUT_TDATA_W-1:0] i_out_tdata,
    output int                                    o_fail_cnt,
    output int                                    o_outstanding
);
    import dees_pkg::*;

    typedef struct packed {
        logic               served;
        logic [TOTAL_W-1:0] total;
        logic               pending;
    } t_tick_result;

    // own copy of the bucket ring, tick position and running total
    logic [CNT_W-1:0]   bucket_cnt [WINDOW];
    int unsigned        now_slot;
    logic [TOTAL_W-1:0] served_sum;

    t_tick_result       due_results [$];
    int                 fail_total = 0;
    int                 results_seen = 0;

    assign o_fail_cnt = fail_total;

    task automatic report_mismatch(input string what, input logic [TOTAL_W-1:0] want_v,
                                   input logic [TOTAL_W-1:0] got_v);
        $display("mismatch on result %0d: %s expected %0h got %0h",
                 results_seen, what, want_v, got_v);
        fail_total++;
    endtask

    // one tick: file arrivals, expire the current bucket, serve the earliest deadline
    task automatic serve_tick(input logic [UNITS_W-1:0] units, input logic [LIFE_W-1:0] life,
                              output t_tick_result res);
        int unsigned      lt;
        int unsigned      slot;
        logic [CNT_W:0]   sum;
        bit               found;
        lt    = life;
        found = 1'b0;
        res   = '0;
        if (lt > WINDOW - 1)
            lt = WINDOW - 1;
        if (units != '0 && lt != 0) begin
            slot = (now_slot + lt) % WINDOW;
            sum  = {1'b0, bucket_cnt[slot]} + {{(CNT_W + 1 - UNITS_W){1'b0}}, units};
            bucket_cnt[slot] = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
        end
        bucket_cnt[now_slot] = '0;
        for (int k = 1; k < WINDOW; k++) begin
            slot = (now_slot + k) % WINDOW;
            if (!found && bucket_cnt[slot] != '0) begin
                bucket_cnt[slot] = bucket_cnt[slot] - CNT_W'(1);
                found = 1'b1;
            end
        end
        if (found && served_sum != TOTAL_MAX)
            served_sum = served_sum + TOTAL_W'(1);
        res.served = found;
        res.total  = served_sum;
        for (int k = 0; k < WINDOW; k++) begin
            if (bucket_cnt[k] != '0)
                res.pending = 1'b1;
        end
        now_slot = (now_slot + 1) % WINDOW;
    endtask

    always @(posedge i_clk) begin
        t_tick_result want;
        t_tick_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++)
                bucket_cnt[i] = '0;
            now_slot   = 0;
            served_sum = '0;
            due_results.delete();
        end else begin
            // compare before filing the new tick, a result never answers its own cycle
            if (i_out_tvalid && i_out_tready) begin
                got.served  = i_out_tdata[0];
                got.total   = i_out_tdata[TOTAL_W:1];
                got.pending = i_out_tdata[TOTAL_W+1];
                if (due_results.size() == 0) begin
                    report_mismatch("result with no tick waiting", '0, got.total);
                end else begin
                    want = due_results.pop_front();
                    if (got.served !== want.served)
                        report_mismatch("served", TOTAL_W'(want.served),
                                        TOTAL_W'(got.served));
                    if (got.total !== want.total)
                        report_mismatch("total_served", want.total, got.total);
                    if (got.pending !== want.pending)
                        report_mismatch("pending", TOTAL_W'(want.pending),
                                        TOTAL_W'(got.pending));
                end
                results_seen++;
            end
            if (i_in_tvalid && i_in_tready) begin
                serve_tick(i_in_tdata[UNITS_W-1:0], i_in_tdata[UNITS_W+LIFE_W-1:UNITS_W], want);
                due_results.push_back(want);
            end
        end
        o_outstanding <= due_results.size();
    end

endmodule

/* tb/sv/deadline_expiry_edf_server_core_test.sv */
// top of the deadline expiry edf server regression: clock, reset, stimulus, verdict
`timescale 1ns / 100ps

module deadline_expiry_edf_server_core_test;

    import dees_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // arrival_units[15:0], lifetime[21:16], zero pad above
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // served[0], total_served[32:1], pending[33], zero pad above
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int                     fail_cnt;
    int                     outstanding;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    bit                     hold_request = 1'b0;
    int                     quiet_cycles = 0;

    // 12 ns period
    always #6 i_clk = ~i_clk;

    deadline_expiry_edf_server_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    edf_service_checker checker_0 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .o_fail_cnt    (fail_cnt),
        .o_outstanding (outstanding)
    );

    // watchdog: too many cycles without any transaction ends the run
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("deadline_expiry_edf_server_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random back-pressure, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one tick and return at the edge where it is taken
    task automatic offer_tick(input logic [UNITS_W-1:0] units, input logic [LIFE_W-1:0] life);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-UNITS_W-LIFE_W){1'b0}}, life, units};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // traffic in segments of one character each, so buckets fill, compete and drain
    task automatic run_traffic(input int n_ticks);
        int                 sent;
        int                 seg_len;
        int                 mode;
        int                 pick;
        logic [UNITS_W-1:0] units;
        logic [LIFE_W-1:0]  life;
        sent = 0;
        while (sent < n_ticks) begin
            mode    = $urandom_range(9);
            seg_len = (mode == 9) ? WINDOW + 8 : $urandom_range(60, 10);
            for (int i = 0; i < seg_len && sent < n_ticks; i++) begin
                units = '0;
                life  = LIFE_W'($urandom_range(WINDOW - 1));
                pick  = $urandom_range(99);
                case (mode)
                    0: begin
                        // mostly zero lifetime, nothing should be filed
                        units = UNITS_W'($urandom);
                        if (pick < 75)
                            life = '0;
                    end
                    1, 2, 3, 4: begin
                        // sparse light load, buckets empty out often
                        if (pick < 30)
                            units = UNITS_W'($urandom_range(3, 1));
                    end
                    5, 6: begin
                        if (pick < 20)
                            units = UNITS_W'($urandom_range(3, 1));
                        else if (pick < 45)
                            units = UNITS_W'($urandom);
                        else if (pick < 55)
                            units = '1;
                        pick = $urandom_range(99);
                        if (pick < 15)
                            life = '1;
                        else if (pick < 30)
                            life = 6'd1;
                    end
                    7: begin
                        // short deadlines, units expire before they are served
                        if (pick < 80)
                            units = UNITS_W'($urandom_range(2, 1));
                        life = LIFE_W'($urandom_range(4, 1));
                    end
                    8: begin
                        units = UNITS_W'($urandom);
                    end
                    default: begin
                        // quiet stretch, every bucket expires
                    end
                endcase
                offer_tick(units, life);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 38;
        recv_idle_pct = 56;

        // directed ticks
        offer_tick(16'd0, 6'd0);         // empty ring, nothing to serve
        offer_tick(16'd5, 6'd0);         // zero lifetime, dropped on arrival
        offer_tick(16'd0, 6'd10);        // zero arrivals, ring unchanged
        offer_tick(16'd3, 6'd1);         // lifetime one: one served, rest expire next tick
        offer_tick(16'd0, 6'd0);         // leftover units expire here
        offer_tick(16'hFFFF, 6'd63);     // most units, longest lifetime
        offer_tick(16'd1, 6'd2);         // earlier deadline jumps ahead
        offer_tick(16'd2, 6'd5);
        offer_tick(16'h5555, 6'h2A);     // alternating bit patterns
        offer_tick(16'hAAAA, 6'h15);
        offer_tick(16'hFFFF, 6'd1);      // large bucket gone after one tick
        offer_tick(16'd1, 6'd63);
        offer_tick(16'd0, 6'd0);
        offer_tick(16'd0, 6'd63);

        run_traffic(560);

        send_idle_pct = 56;
        recv_idle_pct = 38;
        run_traffic(560);

        send_idle_pct = 0;
        recv_idle_pct = 0;

        // long receiver hold-off while ticks keep coming, block backs up into its input
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
            offer_tick(UNITS_W'($urandom_range(3)), LIFE_W'($urandom_range(WINDOW - 1)));
        s_axis_tvalid <= 1'b0;
        // sender pauses until every result is back
        wait_drained();

        run_traffic(540);

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (fail_cnt == 0 && outstanding == 0)
            $display("deadline_expiry_edf_server_core regression: pass");
        else
            $display("deadline_expiry_edf_server_core regression: fail");
        $finish;
    end

endmodule
